FILE: rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes for the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int unsigned FieldWidth = 32;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_GROW,
    S_PUSH,
    S_DONE
  } state_t;

  // Register indexes on the configuration port
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [4:0]            region_id;
    logic [FieldWidth-1:0] request_size;
  } in_req_t;

  typedef struct packed {
    status_t               status;
    logic [FieldWidth-1:0] address;
  } out_res_t;

  // Command from the controller to the cell chain
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_ROTATE,
    CH_PUSH
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    logic      head_drop;
    logic      head_trim;
  } chain_ctl_t;

endpackage

FILE: rtl/ffra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ffra_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_cell
// One slot of the free-span chain: holds a span and passes it to a neighbor.
// ----------------------------------------------------------------------------
module ffra_cell
  import ffra_pkg::*;
#(
  parameter int unsigned AW = 32
) (
  input  logic       clk,
  input  chain_ctl_t ctl,
  input  logic       is_head,
  input  logic [AW-1:0] rot_begin,
  input  logic [AW-1:0] rot_finish,
  input  logic [AW-1:0] push_begin,
  input  logic [AW-1:0] push_finish,
  input  logic [AW-1:0] trim_begin,
  output logic [AW-1:0] begin_q,
  output logic [AW-1:0] finish_q
);

  logic [AW-1:0] begin_r, begin_nxt;
  logic [AW-1:0] finish_r, finish_nxt;

  // Rotate pulls from the next slot, push pulls from the previous one
  always_comb begin
    begin_nxt  = begin_r;
    finish_nxt = finish_r;
    case (ctl.op)
      CH_ROTATE: begin
        begin_nxt  = rot_begin;
        finish_nxt = rot_finish;
        if (is_head && ctl.head_trim) begin
          begin_nxt = trim_begin;
        end
      end
      CH_PUSH: begin
        begin_nxt  = push_begin;
        finish_nxt = push_finish;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    begin_r  <= begin_nxt;
    finish_r <= finish_nxt;
  end

  assign begin_q  = begin_r;
  assign finish_q = finish_r;

endmodule

FILE: rtl/ffra_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_chain
// Row of span cells. Slot 0 is always examined; rotating moves the ring one
// place so every live span passes slot 0 in list order.
// ----------------------------------------------------------------------------
module ffra_chain
  import ffra_pkg::*;
#(
  parameter int unsigned AW    = 32,
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk,
  input  chain_ctl_t    ctl,
  input  logic [$clog2(SLOTS+1)-1:0] count,
  input  logic [AW-1:0] new_begin,
  input  logic [AW-1:0] new_finish,
  input  logic [AW-1:0] trim_begin,
  output logic [AW-1:0] head_begin,
  output logic [AW-1:0] head_finish
);

  logic [AW-1:0] b_q [SLOTS];
  logic [AW-1:0] f_q [SLOTS];

  // Ring rotation: slot i takes slot i+1; the last live slot takes the head,
  // unless the head is being dropped, then it takes the slot after it.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [AW-1:0] rb, rf, pb, pf;
    always_comb begin
      if (i + 1 < SLOTS) begin
        rb = b_q[(i + 1) % SLOTS];
        rf = f_q[(i + 1) % SLOTS];
      end else begin
        rb = b_q[0];
        rf = f_q[0];
      end
      if (count != '0 && ({1'b0, 32'(i)} == {1'b0, 32'(count) - 32'd1}) && !ctl.head_drop) begin
        rb = ctl.head_trim ? trim_begin : b_q[0];
        rf = f_q[0];
      end
      if (i == 0) begin
        pb = new_begin;
        pf = new_finish;
      end else begin
        pb = b_q[(i + SLOTS - 1) % SLOTS];
        pf = f_q[(i + SLOTS - 1) % SLOTS];
      end
    end
    ffra_cell #(.AW(AW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .is_head    (1'b0),
      .rot_begin  (rb),
      .rot_finish (rf),
      .push_begin (pb),
      .push_finish(pf),
      .trim_begin (trim_begin),
      .begin_q    (b_q[i]),
      .finish_q   (f_q[i])
    );
  end

  assign head_begin  = b_q[0];
  assign head_finish = f_q[0];

endmodule

FILE: rtl/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// Allocate/free engine over a first-fit free-span list.
// ----------------------------------------------------------------------------
// Usage: drive in_req with start high while busy is low; the request is taken
// at that edge. Exactly one result appears later on out_res with out_valid
// high for one cycle; the receiver must take it then, it cannot stall.
// Allocate scans the free list by rotating a ring of span cells so each live
// span passes the head slot in order; the scan makes one full turn of the
// ring, so the list ends in its original order. A miss goes on to the grow
// check. Free pushes a non-empty span at the list head while the list has room.
// After the accepting edge a bad id goes straight to the result; free reads
// the region and then pushes its span; an allocate reads the region, scans
// any live spans and on a miss grows the break. One request at a time; busy
// is low from the result cycle on, so the next request can be taken at the
// edge that ends it.
// Region spans live in two RAMs (registered read). Reset clears control
// state and the region valid bits; a region not written reads zero.
// heap_base/heap_limit live on the cfg_ APB port at byte 0 and 4; writing
// heap_base also reloads the heap break.
// ----------------------------------------------------------------------------
module first_fit_region_allocator
  import ffra_pkg::*;
#(
  parameter int unsigned REGION_COUNT = 32,
  parameter int unsigned FREE_SLOTS   = 16,
  parameter int unsigned PAGE_BITS    = 8,
  parameter int unsigned ADDR_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW  = ADDR_WIDTH;
  localparam int unsigned RIW = $clog2(REGION_COUNT);
  localparam int unsigned CW  = $clog2(FREE_SLOTS + 1);
  localparam logic [AW:0] PageMask = (AW+1)'((65'd1 << PAGE_BITS) - 65'd1);
  localparam logic [AW:0] AddrMax  = {1'b0, {AW{1'b1}}};

  state_t state_r, state_nxt;

  logic [AW-1:0] heap_base_r, heap_limit_r, heap_break_r;
  logic          act_r;
  logic [4:0]    id_r;
  logic [AW-1:0] size_r;
  logic [CW-1:0] count_r, left_r;
  logic          found_r;
  logic [AW-1:0] addr_r;
  status_t       status_r;
  logic [REGION_COUNT-1:0] rvalid_r;
  logic [RIW-1:0] rid_q, rd_addr;
  logic [AW-1:0] rb_q, rf_q, rb, rf;
  logic [AW-1:0] hb, hf, span;
  logic          fits, exact, id_ok;
  chain_ctl_t    ctl;
  logic          rwe;
  logic [AW-1:0] rwb, rwf;
  logic [AW:0]   inc, room;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign busy = (state_r != S_IDLE);
  assign id_ok = ({27'd0, in_req.region_id} < 32'(REGION_COUNT));

  // Configuration read mux
  always_comb begin
    unique case (cfg_paddr[2])
      REG_HEAP_BASE:  cfg_prdata = 32'(heap_base_r);
      REG_HEAP_LIMIT: cfg_prdata = 32'(heap_limit_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Region store, rows that were never written read as zero; the read
  // address follows the held id once the request is taken
  assign rid_q   = RIW'(id_r);
  assign rd_addr = (state_r == S_IDLE) ? RIW'(in_req.region_id) : rid_q;
  ffra_ram #(.WIDTH(AW), .DEPTH(REGION_COUNT)) u_rb (
    .clk(clk), .we(rwe), .waddr(rid_q), .wdata(rwb),
    .raddr(rd_addr), .rdata(rb_q));
  ffra_ram #(.WIDTH(AW), .DEPTH(REGION_COUNT)) u_rf (
    .clk(clk), .we(rwe), .waddr(rid_q), .wdata(rwf),
    .raddr(rd_addr), .rdata(rf_q));
  assign rb = rvalid_r[rid_q] ? rb_q : '0;
  assign rf = rvalid_r[rid_q] ? rf_q : '0;

  // Head slot test
  assign span  = hf - hb;
  assign fits  = (hf >= hb) && (size_r <= span);
  assign exact = fits && (size_r == span);
  assign inc   = (({1'b0, size_r} + PageMask) & ~PageMask);
  assign room  = {1'b0, heap_limit_r} - {1'b0, heap_break_r};

  ffra_chain #(.AW(AW), .SLOTS(FREE_SLOTS)) u_chain (
    .clk(clk), .ctl(ctl), .count(count_r),
    .new_begin(rb), .new_finish(rf), .trim_begin(hb + size_r),
    .head_begin(hb), .head_finish(hf));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = id_ok ? S_READ : S_DONE;
      S_READ: begin
        if (act_r == ACT_FREE) state_nxt = S_PUSH;
        else if (count_r == '0) state_nxt = S_GROW;
        else state_nxt = S_SCAN;
      end
      S_SCAN: if (left_r == CW'(1)) state_nxt = (found_r || fits) ? S_DONE : S_GROW;
      S_GROW: state_nxt = S_DONE;
      S_PUSH: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Chain and RAM control
  always_comb begin
    ctl = '{op: CH_HOLD, head_drop: 1'b0, head_trim: 1'b0};
    rwe = 1'b0;
    rwb = '0;
    rwf = '0;
    unique case (state_r)
      S_SCAN: begin
        ctl.op = CH_ROTATE;
        if (!found_r && fits) begin
          ctl.head_drop = exact;
          ctl.head_trim = !exact;
          rwe = 1'b1;
          rwb = hb;
          rwf = hb + size_r;
        end
      end
      S_GROW: begin
        if (!(size_r > AW'(AddrMax - PageMask)) && heap_break_r <= heap_limit_r
            && inc <= room) begin
          rwe = 1'b1;
          rwb = heap_break_r;
          rwf = heap_break_r + size_r;
        end
      end
      S_PUSH: begin
        if (!(rb == '0 && rf == '0)) begin
          rwe = 1'b1;
          if (rb < rf && count_r < CW'(FREE_SLOTS)) ctl.op = CH_PUSH;
        end
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_base_r  <= '0;
      heap_limit_r <= '1;
      heap_break_r <= '0;
      count_r      <= '0;
      rvalid_r     <= '0;
      out_valid    <= 1'b0;
      found_r      <= 1'b0;
      left_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_DONE);
      if (cfg_wr && cfg_paddr[2] == REG_HEAP_BASE) begin
        heap_base_r  <= AW'(cfg_pwdata);
        heap_break_r <= AW'(cfg_pwdata);
      end
      if (cfg_wr && cfg_paddr[2] == REG_HEAP_LIMIT) heap_limit_r <= AW'(cfg_pwdata);
      if (rwe) rvalid_r[rid_q] <= 1'b1;
      unique case (state_r)
        S_IDLE: if (start) begin
          found_r <= 1'b0;
          left_r  <= count_r;
        end
        S_SCAN: begin
          left_r <= left_r - CW'(1);
          if (!found_r && fits) begin
            found_r <= 1'b1;
            if (exact) count_r <= count_r - CW'(1);
          end
        end
        S_GROW: if (rwe) heap_break_r <= heap_break_r + inc[AW-1:0];
        S_PUSH: if (ctl.op == CH_PUSH) count_r <= count_r + CW'(1);
        default: ;
      endcase
    end
  end

  // Request capture and result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      act_r    <= in_req.action;
      id_r     <= in_req.region_id;
      size_r   <= AW'(in_req.request_size);
      status_r <= id_ok ? ST_OK : ST_BAD_ID;
      addr_r   <= '0;
    end
    unique case (state_r)
      S_SCAN: if (!found_r && fits) addr_r <= hb;
      S_GROW: begin
        if (rwe) addr_r <= heap_break_r;
        else status_r <= ST_NO_SPACE;
      end
      S_PUSH: begin
        if (rb == '0 && rf == '0) status_r <= ST_EMPTY;
        else if (rb < rf && count_r >= CW'(FREE_SLOTS)) status_r <= ST_FULL;
      end
      default: ;
    endcase
  end

  // Result ports
  always_comb begin
    out_res.status  = status_r;
    out_res.address = 32'(addr_r);
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(FREE_SLOTS)) else $error("free count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_break_up: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW && rwe) |=> heap_break_r >= $past(heap_break_r))
    else $error("break fell");
`endif

endmodule

FILE: test/tb_first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator
// Drives allocate/free requests and heap register writes into the allocator.
// Its own model of the free-span list, the region table and the heap break
// predicts every status and address, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator;
  import ffra_pkg::*;

  localparam int unsigned NREG  = 32;
  localparam int unsigned NSLOT = 16;
  localparam int unsigned PBITS = 8;
  localparam logic [31:0] PMASK = (32'd1 << PBITS) - 32'd1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state
  logic [31:0] span_lo [NSLOT];
  logic [31:0] span_hi [NSLOT];
  int unsigned span_cnt;
  logic [31:0] reg_lo [NREG];
  logic [31:0] reg_hi [NREG];
  logic [31:0] brk;
  logic [31:0] limit_val;

  out_res_t    pending_q[$];
  int unsigned mismatches;
  int unsigned burst_left;

  first_fit_region_allocator u_top (.*);

  // Clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  // Predict the result of one request and update the model
  function automatic out_res_t predict_request(input in_req_t r);
    out_res_t    res;
    logic [31:0] b;
    logic [31:0] f;
    logic [32:0] inc;
    logic        found;
    int unsigned id;
    res.status = ST_OK;
    res.address = '0;
    id = r.region_id;
    found = 1'b0;
    if (r.action == ACT_ALLOC) begin
      for (int k = 0; k < span_cnt && !found; k++) begin
        b = span_lo[k];
        f = span_hi[k];
        if (f >= b && r.request_size <= f - b) begin
          found = 1'b1;
          reg_lo[id] = b;
          reg_hi[id] = b + r.request_size;
          res.address = b;
          if (r.request_size < f - b) begin
            span_lo[k] = b + r.request_size;
          end else begin
            for (int i = k; i + 1 < span_cnt; i++) begin
              span_lo[i] = span_lo[i+1];
              span_hi[i] = span_hi[i+1];
            end
            span_cnt--;
          end
        end
      end
      if (!found) begin
        inc = ({1'b0, r.request_size} + PMASK) & ~{1'b0, PMASK};
        if (r.request_size > 32'hFFFF_FFFF - PMASK || brk > limit_val ||
            inc > {1'b0, limit_val - brk}) begin
          res.status = ST_NO_SPACE;
        end else begin
          reg_lo[id] = brk;
          reg_hi[id] = brk + r.request_size;
          res.address = brk;
          brk = brk + inc[31:0];
        end
      end
    end else begin
      b = reg_lo[id];
      f = reg_hi[id];
      if (b == 0 && f == 0) begin
        res.status = ST_EMPTY;
      end else begin
        reg_lo[id] = '0;
        reg_hi[id] = '0;
        if (b < f) begin
          if (span_cnt >= NSLOT) begin
            res.status = ST_FULL;
          end else begin
            for (int i = span_cnt; i > 0; i--) begin
              span_lo[i] = span_lo[i-1];
              span_hi[i] = span_hi[i-1];
            end
            span_lo[0] = b;
            span_hi[0] = f;
            span_cnt++;
          end
        end
      end
    end
    return res;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_res_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_res.address, '0);
      end else begin
        exp_res = pending_q.pop_front();
        if (out_res.status !== exp_res.status)
          report("status", 32'(out_res.status), 32'(exp_res.status));
        if (out_res.address !== exp_res.address)
          report("address", out_res.address, exp_res.address);
      end
    end
  end

  // Send one request, with bursty gaps
  task automatic send_request(input action_t act, input logic [4:0] id,
                              input logic [31:0] size);
    in_req_t r;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    r.action = act;
    r.region_id = id;
    r.request_size = size;
    in_req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_request(r));
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (NSLOT + 8) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_HEAP_BASE) begin
      brk = val;
    end else begin
      limit_val = val;
    end
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'd0;
      2: return $urandom_range(0, 4095);
      default: return $urandom_range(1, 700);
    endcase
  endfunction

  // Directed: extremes of fields, both actions, the OK, empty and no-space statuses
  task automatic test_directed;
    send_request(ACT_FREE, 5'd0, 32'd0);           // free of empty region
    send_request(ACT_ALLOC, 5'd1, 32'd0);          // zero size at break 0
    send_request(ACT_FREE, 5'd1, 32'd0);           // empty span still empty
    send_request(ACT_ALLOC, 5'd2, 32'd1);
    send_request(ACT_ALLOC, 5'd3, 32'd256);
    send_request(ACT_ALLOC, 5'd31, 32'd300);
    send_request(ACT_ALLOC, 5'd4, 32'hFFFF_FFFF);  // no space
    send_request(ACT_ALLOC, 5'd5, 32'hFFFF_FF00);  // no space
    send_request(ACT_FREE, 5'd3, 32'hFFFF_FFFF);   // span to head
    send_request(ACT_ALLOC, 5'd6, 32'd100);        // carve front
    send_request(ACT_ALLOC, 5'd7, 32'd156);        // exact fit
    send_request(ACT_ALLOC, 5'd2, 32'd10);         // over live region
    send_request(ACT_FREE, 5'd31, 32'd0);
    send_request(ACT_FREE, 5'd31, 32'd0);
    drain();
    write_reg(REG_HEAP_LIMIT, 32'd1024);
    write_reg(REG_HEAP_BASE, 32'd512);
    send_request(ACT_ALLOC, 5'd8, 32'd512);
    send_request(ACT_ALLOC, 5'd9, 32'd1);          // past limit
    drain();
    write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 5'd10, 32'd3840);
    send_request(ACT_ALLOC, 5'd11, 32'd1);         // address width exhausted
    drain();
  endtask

  // Fill the free table past its capacity
  task automatic test_table_full;
    write_reg(REG_HEAP_BASE, 32'h0001_0000);
    for (int i = 0; i < 20; i++) send_request(ACT_ALLOC, i[4:0], 32'd8);
    for (int i = 0; i < 20; i++) send_request(ACT_FREE, i[4:0], 32'd0);
    drain();
  endtask

  // Random mix with a few register settings
  task automatic test_random;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_HEAP_BASE, 32'd0);
          write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_HEAP_BASE, $urandom());
          write_reg(REG_HEAP_LIMIT, $urandom());
        end
        2: begin
          write_reg(REG_HEAP_BASE, 32'h0000_1000);
          write_reg(REG_HEAP_LIMIT, 32'h0000_8000);
        end
        default: begin
          write_reg(REG_HEAP_LIMIT, 32'd0);
          write_reg(REG_HEAP_BASE, 32'd0);
        end
      endcase
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(0, 1))
          send_request(ACT_ALLOC, 5'($urandom_range(0, 31)), rand_size());
        else
          send_request(ACT_FREE, 5'($urandom_range(0, 31)), $urandom());
        if (n == 45) drain();
      end
      drain();
    end
  endtask

  initial begin
    mismatches = 0;
    burst_left = 0;
    span_cnt = 0;
    for (int i = 0; i < NSLOT; i++) begin
      span_lo[i] = '0;
      span_hi[i] = '0;
    end
    for (int i = 0; i < NREG; i++) begin
      reg_lo[i] = '0;
      reg_hi[i] = '0;
    end
    limit_val = 32'hFFFF_FFFF;
    brk = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ffra_pkg.sv
rtl/ffra_ram.sv
rtl/ffra_cell.sv
rtl/ffra_chain.sv
rtl/first_fit_region_allocator.sv
test/tb_first_fit_region_allocator.sv
